// ----- hw/rtl/pch_pkg.sv -----
// Shared types, constants and helpers for the path component hash block.
// Used by pch_close_pipe and path_component_hash_core; depends on nothing.
`default_nettype none

package pch_pkg;

  // Datapath widths fixed by the hash definition.
  localparam int HASH_W   = 64;
  localparam int DIGEST_W = 32;
  localparam int BYTE_W   = 8;

  // Default bytes per little-endian group.
  localparam int WORD_BYTES_DEF = 8;

  // Depth of the result queue, which also bounds the paths in flight.
  localparam int OUT_DEPTH = 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_COUNT  = 2'd0,
    REG_SEP_FIRST  = 2'd1,
    REG_SEP_SECOND = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [1:0]        SEP_COUNT_RST  = 2'd1;
  localparam logic [BYTE_W-1:0] SEP_FIRST_RST  = 8'd47;
  localparam logic [BYTE_W-1:0] SEP_SECOND_RST = 8'd0;

  // Operands of one component close, handed to the hash pipeline.
  // The final hash is h = ((pre * (pre_mul ? 9 : 1)) + ((a + b) << (sh ? 8 : 0)))
  // multiplied once more by nine when fmul is set.
  typedef struct packed {
    logic              vld;
    logic              lst;
    logic              contrib;
    logic              pre_mul;
    logic              sh;
    logic              fmul;
    logic [HASH_W-1:0] pre;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } close_req_t;

  // Folded component hash leaving the pipeline.
  typedef struct packed {
    logic                vld;
    logic                lst;
    logic                contrib;
    logic [DIGEST_W-1:0] fold;
  } fold_res_t;

  // Multiply by nine as a shift and add, modulo 2^64.
  function automatic logic [HASH_W-1:0] mul9(input logic [HASH_W-1:0] x);
    return x + {x[HASH_W-4:0], 3'b000};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pch_close_pipe.sv -----
// Pipeline that turns the operands of a closed component into its folded hash.
// Depends on pch_pkg for the request and result structs and the mul9 helper.
`default_nettype none

module pch_close_pipe
  import pch_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire close_req_t req,
  output fold_res_t       res
);

  typedef struct packed {
    logic              vld;
    logic              lst;
    logic              contrib;
    logic              fmul;
    logic [HASH_W-1:0] base;
    logic [HASH_W-1:0] addend;
  } st2_t;

  typedef struct packed {
    logic              vld;
    logic              lst;
    logic              contrib;
    logic              fmul;
    logic [HASH_W-1:0] sum;
  } st3_t;

  typedef struct packed {
    logic              vld;
    logic              lst;
    logic              contrib;
    logic [HASH_W-1:0] h;
  } st4_t;

  close_req_t        r1;
  st2_t              r2;
  st3_t              r3;
  st4_t              r4;
  logic [HASH_W-1:0] ab_sum;

  assign ab_sum = r1.a + r1.b;

  always_ff @(posedge clk) begin
    // Input register.
    if (rst) begin
      r1 <= '0;
    end else begin
      r1 <= req;
    end

    // Scale the base and build the addend in parallel.
    r2.vld     <= r1.vld & ~rst;
    r2.lst     <= r1.lst;
    r2.contrib <= r1.contrib;
    r2.fmul    <= r1.fmul;
    r2.base    <= r1.pre_mul ? mul9(r1.pre) : r1.pre;
    r2.addend  <= r1.sh ? {ab_sum[HASH_W-9:0], 8'h00} : ab_sum;

    // One wide add.
    r3.vld     <= r2.vld & ~rst;
    r3.lst     <= r2.lst;
    r3.contrib <= r2.contrib;
    r3.fmul    <= r2.fmul;
    r3.sum     <= r2.base + r2.addend;

    // Final multiply by nine.
    r4.vld     <= r3.vld & ~rst;
    r4.lst     <= r3.lst;
    r4.contrib <= r3.contrib;
    r4.h       <= r3.fmul ? mul9(r3.sum) : r3.sum;
  end

  // Fold the 64-bit hash to 32 bits: low half plus high half.
  always_comb begin
    res.vld     = r4.vld;
    res.lst     = r4.lst;
    res.contrib = r4.contrib;
    res.fold    = r4.h[DIGEST_W-1:0] + r4.h[HASH_W-1:DIGEST_W];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/path_component_hash_core.sv -----
// Top level of the path component hash block: byte front end, digest
// accumulation and result queue. Depends on pch_pkg and pch_close_pipe.
`default_nettype none

//  Channel   Signals                                   Direction
//  path      path_valid, path_stall, path_byte, last   request in
//  digest    digest_valid, digest_stall, digest        request out
//  config    cfg_wen, cfg_index, cfg_data              register write in
//
// One path byte is taken every cycle while path_stall is low; the front end updates the group and
// tail registers with one 64-bit add per byte.
// A digest enters the result queue after its last byte is taken: the close
// pipeline captures the request at the accepting edge and passes it through its
// three further stages before the queue write.
// Reset is synchronous and active high; it restores the separator registers
// and clears all path state, the pipeline and the result queue.
// Up to eight paths may be outstanding; path_stall rises only when eight
// digests are in the pipeline or waiting in the queue.

module path_component_hash_core
  import pch_pkg::*;
#(
  parameter int WORD_BYTES = WORD_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 path_valid,
  output      logic                 path_stall,
  input  wire logic [BYTE_W-1:0]    path_byte,
  input  wire logic                 last,

  output      logic                 digest_valid,
  input  wire logic                 digest_stall,
  output      logic [DIGEST_W-1:0]  digest,

  input  wire logic                 cfg_wen,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  localparam int BCNT_W = $clog2(WORD_BYTES);
  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CRED_W = $clog2(OUT_DEPTH + 1);

  // Configuration registers.
  logic [1:0]        sep_count;
  logic [BYTE_W-1:0] sep_first;
  logic [BYTE_W-1:0] sep_second;

  // Per-path state. A completed group leaves its sum in grp_sum, and the
  // multiply by nine lands in component_hash on the following cycle; the
  // next group cannot complete before then.
  logic [HASH_W-1:0]   word_gather;
  logic [HASH_W-1:0]   tail_pack;
  logic [BCNT_W-1:0]   bytes_in_group;
  logic [HASH_W-1:0]   component_hash;
  logic [HASH_W-1:0]   grp_sum;
  logic                grp_pend;
  logic                component_nonempty;
  logic                terminated;
  logic [DIGEST_W-1:0] running_digest;

  // Result queue and the count of digests owed to the output side.
  logic [DIGEST_W-1:0] fifo_mem [OUT_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CRED_W-1:0]   fifo_count;
  logic [CRED_W-1:0]   credit;

  // Front-end decode.
  logic                acc;
  logic                is_zero;
  logic                is_sep;
  logic                absorb;
  logic                close;
  logic                group_done;
  logic [HASH_W-1:0]   sx;
  logic [HASH_W-1:0]   tail_sum;
  logic [HASH_W-1:0]   tail_shift;
  logic [HASH_W-1:0]   word_full;
  close_req_t          creq;
  fold_res_t           fres;
  logic [DIGEST_W-1:0] dig_upd;
  logic                fifo_wr;
  logic                fifo_rd;

  assign acc     = path_valid & ~path_stall;
  assign is_zero = (path_byte == '0);

  always_comb begin
    unique case (sep_count)
      2'd0:    is_sep = 1'b0;
      2'd1:    is_sep = (path_byte == sep_first);
      default: is_sep = (path_byte == sep_first) | (path_byte == sep_second);
    endcase
  end

  // A zero byte ends the path before any separator compare.
  assign absorb     = acc & ~terminated & ~is_zero & ~is_sep;
  assign close      = acc & ~terminated & (is_zero | is_sep | last);
  assign group_done = absorb & (bytes_in_group == BCNT_W'(WORD_BYTES - 1));

  // Tail bytes are sign-extended before they are packed.
  assign sx         = {{(HASH_W - BYTE_W){path_byte[BYTE_W-1]}}, path_byte};
  assign tail_sum   = tail_pack + sx;
  assign tail_shift = {tail_sum[HASH_W-9:0], 8'h00};
  assign word_full  = word_gather
                    | ({{(HASH_W - BYTE_W){1'b0}}, path_byte} << {bytes_in_group, 3'b000});

  // Operands of a close, taken from the state as it stands after this byte
  // has been absorbed. The heavy arithmetic runs in the close pipeline.
  always_comb begin
    creq.vld     = acc;
    creq.lst     = acc & last;
    creq.contrib = close & (component_nonempty | absorb);
    creq.pre     = grp_pend ? grp_sum : component_hash;
    creq.pre_mul = grp_pend;
    priority if (group_done) begin
      // The byte completes a group: fold the whole word in.
      creq.a    = word_full;
      creq.b    = '0;
      creq.sh   = 1'b0;
      creq.fmul = 1'b1;
    end else if (absorb) begin
      // The byte extends a tail, so the tail update is finished downstream.
      creq.a    = tail_pack;
      creq.b    = sx;
      creq.sh   = 1'b1;
      creq.fmul = 1'b1;
    end else if (bytes_in_group != '0) begin
      creq.a    = tail_pack;
      creq.b    = '0;
      creq.sh   = 1'b0;
      creq.fmul = 1'b1;
    end else begin
      // No tail: the component hash is used as it is.
      creq.a    = '0;
      creq.b    = '0;
      creq.sh   = 1'b0;
      creq.fmul = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_count          <= SEP_COUNT_RST;
      sep_first          <= SEP_FIRST_RST;
      sep_second         <= SEP_SECOND_RST;
      word_gather        <= '0;
      tail_pack          <= '0;
      bytes_in_group     <= '0;
      component_hash     <= '0;
      grp_sum            <= '0;
      grp_pend           <= 1'b0;
      component_nonempty <= 1'b0;
      terminated         <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_SEP_COUNT:  sep_count  <= cfg_data[1:0];
          REG_SEP_FIRST:  sep_first  <= cfg_data;
          REG_SEP_SECOND: sep_second <= cfg_data;
          default: ;
        endcase
      end

      // A close or the end of the path wipes the component; otherwise a
      // pending group lands and the byte is absorbed.
      if (close | (acc & last)) begin
        word_gather        <= '0;
        tail_pack          <= '0;
        bytes_in_group     <= '0;
        component_hash     <= '0;
        grp_pend           <= 1'b0;
        component_nonempty <= 1'b0;
      end else begin
        grp_pend <= group_done;
        if (grp_pend) begin
          component_hash <= mul9(grp_sum);
        end
        if (absorb) begin
          component_nonempty <= 1'b1;
          if (group_done) begin
            grp_sum        <= component_hash + word_full;
            word_gather    <= '0;
            tail_pack      <= '0;
            bytes_in_group <= '0;
          end else begin
            word_gather    <= word_full;
            tail_pack      <= tail_shift;
            bytes_in_group <= bytes_in_group + 1'b1;
          end
        end
      end

      if (acc & last) begin
        terminated <= 1'b0;
      end else if (acc & ~terminated & is_zero) begin
        terminated <= 1'b1;
      end
    end
  end

  pch_close_pipe u_close_pipe (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .res (fres)
  );

  // Digest accumulation at the end of the pipeline. Requests arrive in
  // path order, so the running digest needs no forwarding.
  assign dig_upd = running_digest ^ (fres.contrib ? fres.fold : '0);
  assign fifo_wr = fres.vld & fres.lst;
  assign fifo_rd = digest_valid & ~digest_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_digest <= '0;
    end else if (fres.vld) begin
      running_digest <= fres.lst ? '0 : dig_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem[wr_ptr] <= dig_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      credit     <= '0;
    end else begin
      if (fifo_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (fifo_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + CRED_W'(fifo_wr) - CRED_W'(fifo_rd);
      credit     <= credit + CRED_W'(acc & last) - CRED_W'(fifo_rd);
    end
  end

  // Every path whose digest is owed holds a credit, whether in the
  // pipeline or in the queue, so the queue never overflows.
  assign path_stall   = (credit == CRED_W'(OUT_DEPTH));
  assign digest_valid = (fifo_count != '0);
  assign digest       = fifo_mem[rd_ptr];

`ifndef SYNTHESIS
  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= credit)
    else $error("result queue holds more digests than outstanding credits");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_wr |-> (fifo_count != CRED_W'(OUT_DEPTH)) || fifo_rd)
    else $error("digest written into a full result queue");

  a_path_end_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && last) |=> (!terminated && !component_nonempty && bytes_in_group == '0))
    else $error("path state not cleared after the final byte");

  a_group_pend_fresh: assert property (@(posedge clk) disable iff (rst)
    grp_pend |-> (bytes_in_group == '0) && $past(group_done))
    else $error("pending group hash overlaps a partial group");
`endif

endmodule

`default_nettype wire
